FILE: rtl/ampd_pkg.sv
// ----------------------------------------------------------------------------
// ampd_pkg: shared types and constants of the min/max peak decimator
// Widths of the sample path, the configuration registers and the window
// record that travels from the front end to the result drain.
// ----------------------------------------------------------------------------
`default_nettype none

package ampd_pkg;

  // channel and sample sizing
  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
  localparam int MAG_W        = SAMPLE_BITS - 1;

  // configuration registers
  localparam int CCOUNT_W        = 4;
  localparam int RATE_W          = 19;
  localparam int CFG_DATA_W      = RATE_W;
  localparam int CFG_INDEX_W     = 2;
  localparam int PEAK_RATE_SHIFT = 11;
  localparam int WIN_W           = RATE_W - PEAK_RATE_SHIFT;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_HZ       = CFG_INDEX_W'(1);

  localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RESET = CCOUNT_W'(2);
  localparam logic [RATE_W-1:0]   RATE_HZ_RESET       = RATE_W'(48000);

  // window ordinal
  localparam int INDEX_W = 32;

  // window queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one finished window, all channels
  typedef struct packed {
    logic [INDEX_W-1:0]                       index;
    logic [CNT_W-1:0]                         chans;
    logic                                     final_flag;
    logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] mins;
    logic [MAX_CHANNELS-1:0][MAG_W-1:0]       maxs;
  } window_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: rtl/ampd_front.sv
// ----------------------------------------------------------------------------
// ampd_front: sample intake and per-channel min/max folding
// Holds the configuration, the frame buffer and the running window extremes,
// and hands each finished window to the queue as one record.
// ----------------------------------------------------------------------------
`default_nettype none

module ampd_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write_enable,
  input  wire logic [ampd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ampd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                sample_valid,
  input  wire logic signed [ampd_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                                end_of_stream,
  input  wire ampd_pkg::queue_status_t             qstat,
  output logic                                     sample_stall,
  output logic                                     push,
  output ampd_pkg::window_t                        push_data
);

  // configuration registers
  logic [ampd_pkg::CCOUNT_W-1:0] channel_count;
  logic [ampd_pkg::RATE_W-1:0]   rate_hz;

  // stream state
  logic [ampd_pkg::SAMPLE_BITS-1:0] frame_buffer [ampd_pkg::MAX_CHANNELS];
  logic [ampd_pkg::MAX_CHANNELS-1:0][ampd_pkg::SAMPLE_BITS-1:0] channel_minimum;
  logic [ampd_pkg::MAX_CHANNELS-1:0][ampd_pkg::MAG_W-1:0]       channel_maximum;
  logic [ampd_pkg::CH_W-1:0]    channel_position;
  logic [ampd_pkg::WIN_W-1:0]   frames_in_window;
  logic [ampd_pkg::INDEX_W-1:0] window_counter;

  logic [ampd_pkg::CNT_W-1:0]   chans;
  logic [ampd_pkg::WIN_W-1:0]   win;
  logic                         active;
  logic                         accept;
  logic [ampd_pkg::CNT_W-1:0]   pos_inc;
  logic                         frame_done;
  logic [ampd_pkg::WIN_W-1:0]   frames_next;
  logic                         emit;
  logic [ampd_pkg::MAX_CHANNELS-1:0][ampd_pkg::SAMPLE_BITS-1:0] min_next;
  logic [ampd_pkg::MAX_CHANNELS-1:0][ampd_pkg::MAG_W-1:0]       max_next;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= ampd_pkg::CHANNEL_COUNT_RESET;
      rate_hz       <= ampd_pkg::RATE_HZ_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        ampd_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[ampd_pkg::CCOUNT_W-1:0];
        ampd_pkg::REG_RATE_HZ:       rate_hz       <= cfg_data[ampd_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective channel count and window length
  always_comb begin
    if ({1'b0, channel_count} > (ampd_pkg::CCOUNT_W + 1)'(ampd_pkg::MAX_CHANNELS)) begin
      chans = ampd_pkg::CNT_W'(ampd_pkg::MAX_CHANNELS);
    end else begin
      chans = ampd_pkg::CNT_W'(channel_count);
    end
    win = rate_hz[ampd_pkg::RATE_W-1:ampd_pkg::PEAK_RATE_SHIFT];
    if (win == '0) begin
      win = ampd_pkg::WIN_W'(1);
    end
  end

  assign active       = (chans != '0) && (rate_hz != '0);
  assign sample_stall = qstat.full;
  assign accept       = sample_valid && !sample_stall;

  // frame completion and window fill
  assign pos_inc     = ampd_pkg::CNT_W'(channel_position) + ampd_pkg::CNT_W'(1);
  assign frame_done  = (pos_inc >= chans);
  assign frames_next = frames_in_window + ampd_pkg::WIN_W'(frame_done);
  assign emit        = active && ((frames_next >= win) ||
                                  (end_of_stream && (frames_next != '0)));

  // fold the completed frame into each active channel (below chans) in parallel
  always_comb begin
    logic [ampd_pkg::SAMPLE_BITS-1:0] s;
    for (int c = 0; c < ampd_pkg::MAX_CHANNELS; c++) begin
      s = (ampd_pkg::CH_W'(c) == channel_position) ? sample : frame_buffer[c];
      min_next[c] = channel_minimum[c];
      max_next[c] = channel_maximum[c];
      if (frame_done && (ampd_pkg::CNT_W'(c) < chans)) begin
        if ($signed(s) < $signed(channel_minimum[c])) begin
          min_next[c] = s;
        end
        if (!s[ampd_pkg::SAMPLE_BITS-1] && (s[ampd_pkg::MAG_W-1:0] > channel_maximum[c])) begin
          max_next[c] = s[ampd_pkg::MAG_W-1:0];
        end
      end
    end
  end

  // window record toward the queue
  assign push                 = accept && emit;
  assign push_data.index      = window_counter;
  assign push_data.chans      = chans;
  assign push_data.final_flag = end_of_stream;
  assign push_data.mins       = min_next;
  assign push_data.maxs       = max_next;

  // frame buffer write, no reset
  always_ff @(posedge clk) begin
    if (accept && active) begin
      frame_buffer[channel_position] <= sample;
    end
  end

  // stream state update
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_minimum  <= '0;
      channel_maximum  <= '0;
      channel_position <= '0;
      frames_in_window <= '0;
      window_counter   <= '0;
    end else if (accept) begin
      if (end_of_stream) begin
        channel_minimum  <= '0;
        channel_maximum  <= '0;
        channel_position <= '0;
        frames_in_window <= '0;
        window_counter   <= '0;
      end else if (active) begin
        channel_position <= frame_done ? '0 : pos_inc[ampd_pkg::CH_W-1:0];
        if (emit) begin
          channel_minimum  <= '0;
          channel_maximum  <= '0;
          frames_in_window <= '0;
          window_counter   <= window_counter + ampd_pkg::INDEX_W'(1);
        end else begin
          channel_minimum  <= min_next;
          channel_maximum  <= max_next;
          frames_in_window <= frames_next;
        end
      end
    end
  end

  // a pushed window always carries at least one channel
  a_push_chans: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.chans != '0))
    else $error("window pushed with no channels");

  // nothing is pushed into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("window pushed while queue full");

  // an end-of-stream transaction leaves the stream state cleared
  a_eos_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_stream) |=> ((channel_position == '0) &&
                                   (frames_in_window == '0) &&
                                   (window_counter == '0)))
    else $error("stream state not cleared after end of stream");

endmodule

`default_nettype wire

FILE: rtl/ampd_queue.sv
// ----------------------------------------------------------------------------
// ampd_queue: short queue of finished windows
// Decouples the intake side from the result drain; holds whole window records.
// ----------------------------------------------------------------------------
`default_nettype none

module ampd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire ampd_pkg::window_t  push_data,
  input  wire logic               pop,
  output ampd_pkg::window_t       head,
  output ampd_pkg::queue_status_t qstat
);

  ampd_pkg::window_t              entries [ampd_pkg::QUEUE_DEPTH];
  logic [ampd_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ampd_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ampd_pkg::QCNT_W-1:0]    count;

  // pointer wrap helper
  function automatic logic [ampd_pkg::QPTR_W-1:0] ptr_inc(
    input logic [ampd_pkg::QPTR_W-1:0] p
  );
    if (p == ampd_pkg::QPTR_W'(ampd_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + ampd_pkg::QPTR_W'(1);
  endfunction

  assign qstat.full  = (count == ampd_pkg::QCNT_W'(ampd_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = entries[rd_ptr];

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + ampd_pkg::QCNT_W'(1);
        2'b01:   count <= count - ampd_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // no pop from an empty queue
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // fill count advances on a push without a pop
  a_count: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + ampd_pkg::QCNT_W'(1)))
    else $error("queue count did not advance on push");

  // fill count never exceeds the depth
  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ampd_pkg::QCNT_W'(ampd_pkg::QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

`default_nettype wire

FILE: rtl/ampd_back.sv
// ----------------------------------------------------------------------------
// ampd_back: result drain
// Walks the channels of the head window into the output register one per
// cycle unless the output stalls; releases the window after its last channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ampd_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire ampd_pkg::window_t                    head,
  input  wire ampd_pkg::queue_status_t              qstat,
  output logic                                      pop,
  output logic                                      peak_valid,
  input  wire logic                                 peak_stall,
  output logic [ampd_pkg::INDEX_W-1:0]              peak_index,
  output logic [ampd_pkg::CH_W-1:0]                 peak_channel,
  output logic signed [ampd_pkg::SAMPLE_BITS-1:0]   peak_min,
  output logic [ampd_pkg::MAG_W-1:0]                peak_max,
  output logic                                      last_channel,
  output logic                                      final_peak
);

  logic [ampd_pkg::CH_W-1:0]  ch;
  logic [ampd_pkg::CNT_W-1:0] ch_inc;
  logic                       load;
  logic                       is_last;

  assign load    = !qstat.empty && (!peak_valid || !peak_stall);
  assign ch_inc  = ampd_pkg::CNT_W'(ch) + ampd_pkg::CNT_W'(1);
  assign is_last = (ch_inc == head.chans);
  assign pop     = load && is_last;

  // channel walk
  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (load) begin
      ch <= is_last ? '0 : ch_inc[ampd_pkg::CH_W-1:0];
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (load) begin
      peak_valid <= 1'b1;
    end else if (!peak_stall) begin
      peak_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      peak_index   <= head.index;
      peak_channel <= ch;
      peak_min     <= head.mins[ch];
      peak_max     <= head.maxs[ch];
      last_channel <= is_last;
      final_peak   <= head.final_flag;
    end
  end

  // the channel walk stays inside the head window
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    !qstat.empty |-> (ampd_pkg::CNT_W'(ch) < head.chans))
    else $error("channel walk past window channel count");

  // a window is released only with its last channel on the output
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (peak_valid && last_channel))
    else $error("window released without last channel");

  // a fresh window starts its walk at channel zero
  a_walk_reset: assert property (@(posedge clk) disable iff (rst)
    pop |=> (ch == '0))
    else $error("channel walk not restarted");

endmodule

`default_nettype wire

FILE: rtl/audio_min_max_peak_decimator.sv
// ----------------------------------------------------------------------------
// audio_min_max_peak_decimator: per-channel min/max peak decimation
// Interleaved audio samples in, one min/max pair per channel per window out.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake                 | payload
//   sample   | in        | sample_valid/sample_stall | sample, end_of_stream
//   peak     | out       | peak_valid/peak_stall     | peak_index .. final_peak
//   config   | in        | cfg_write_enable          | cfg_index, cfg_data
//
// One sample transaction per cycle while the window queue has room.
// Each finished window drains one result per channel, one per cycle unless
// the output stalls, via a two-entry queue; intake stalls only when full.
// Synchronous reset clears stream state and loads default configuration.
// Output stall holds the result register and, via the queue, the intake.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_min_max_peak_decimator (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_enable,
  input  wire logic [ampd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [ampd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 sample_valid,
  output logic                                      sample_stall,
  input  wire logic signed [ampd_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                                 end_of_stream,
  output logic                                      peak_valid,
  input  wire logic                                 peak_stall,
  output logic [ampd_pkg::INDEX_W-1:0]              peak_index,
  output logic [ampd_pkg::CH_W-1:0]                 peak_channel,
  output logic signed [ampd_pkg::SAMPLE_BITS-1:0]   peak_min,
  output logic [ampd_pkg::MAG_W-1:0]                peak_max,
  output logic                                      last_channel,
  output logic                                      final_peak
);

  ampd_pkg::window_t       push_data;
  ampd_pkg::window_t       head;
  ampd_pkg::queue_status_t qstat;
  logic                    push;
  logic                    pop;

  // intake and folding
  ampd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_valid     (sample_valid),
    .sample           (sample),
    .end_of_stream    (end_of_stream),
    .qstat            (qstat),
    .sample_stall     (sample_stall),
    .push             (push),
    .push_data        (push_data)
  );

  // window queue
  ampd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // result drain
  ampd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .peak_valid   (peak_valid),
    .peak_stall   (peak_stall),
    .peak_index   (peak_index),
    .peak_channel (peak_channel),
    .peak_min     (peak_min),
    .peak_max     (peak_max),
    .last_channel (last_channel),
    .final_peak   (final_peak)
  );

endmodule

`default_nettype wire
